FILE: rtl/core/masked_kmer_window_assert.svh
// Assertion macros for the masked k-mer window block.
`ifndef MASKED_KMER_WINDOW_ASSERT_SVH
`define MASKED_KMER_WINDOW_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define MKW_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define MKW_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mkw_pkg.sv
// Shared types, constants and the base decoder of the masked k-mer window.
`timescale 1ns / 1ps

package mkw_pkg;

    localparam int MAX_WINDOW_DEF = 32;

    localparam int CHAR_W    = 8;
    localparam int LEN_W     = 6;
    localparam int MASK_W    = 32;
    localparam int CODES_W   = 64;
    localparam int FLAGS_W   = 32;
    localparam int COUNT_W   = 6;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 4;

    typedef logic [2:0] base_t;

    localparam base_t BASE_A   = 3'd0;
    localparam base_t BASE_C   = 3'd1;
    localparam base_t BASE_G   = 3'd2;
    localparam base_t BASE_T   = 3'd3;
    localparam base_t BASE_N   = 3'd4;
    localparam base_t BASE_BAD = 3'd5;

    localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;
    localparam logic [CHAR_W-1:0] CHAR_N = 8'h4E;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_MASK   = 4'd1;

    localparam logic [LEN_W-1:0]  LEN_RESET  = 6'd32;
    localparam logic [MASK_W-1:0] MASK_RESET = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [CHAR_W-1:0] base_char;
    } in_word_t;

    typedef struct packed {
        logic                accepted;
        base_t               evicted_base;
        logic [CODES_W-1:0]  selected_codes;
        logic [FLAGS_W-1:0]  selected_n_flags;
        logic [COUNT_W-1:0]  selected_count;
    } out_word_t;

    function automatic base_t decode_base(input logic [CHAR_W-1:0] c);
        base_t b;
        case (c)
            CHAR_A:  b = BASE_A;
            CHAR_C:  b = BASE_C;
            CHAR_G:  b = BASE_G;
            CHAR_T:  b = BASE_T;
            CHAR_N:  b = BASE_N;
            default: b = BASE_BAD;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/core/mkw_stream_if.sv
// Valid/ready stream interface that carries one payload word per handshake.
`timescale 1ns / 1ps

interface mkw_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/mkw_sel_map.sv
// Configuration registers and the derived position-to-slot map.
`timescale 1ns / 1ps

module mkw_sel_map
    import mkw_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int RANK_W     = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    output logic [RANK_W-1:0]     len_last,
    output logic [MAX_WINDOW-1:0] sel,
    output logic [MAX_WINDOW-1:0][RANK_W-1:0] rank,
    output logic [COUNT_W-1:0]    count
);

    typedef logic [MAX_WINDOW-1:0][RANK_W-1:0] rank_vec_t;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WINDOW);

    logic [LEN_W-1:0]      window_length_reg, window_length_next;
    logic [MASK_W-1:0]     select_mask_reg, select_mask_next;
    logic [RANK_W-1:0]     len_last_reg, len_last_next, len_last_rst;
    logic [MAX_WINDOW-1:0] sel_reg, sel_next, sel_rst;
    rank_vec_t             rank_reg, rank_next, rank_rst;
    logic [COUNT_W-1:0]    count_reg, count_next, count_rst;

    // Zero acts as one, anything above the depth acts as the full depth.
    function automatic logic [RANK_W-1:0] f_len_last(input logic [LEN_W-1:0] wl);
        logic [RANK_W-1:0] r;
        if (wl == '0)
            r = '0;
        else if (wl > MAX_LEN)
            r = RANK_W'(MAX_WINDOW - 1);
        else
            r = RANK_W'(wl - 6'd1);
        return r;
    endfunction

    function automatic logic [MAX_WINDOW-1:0] f_sel(input logic [MASK_W-1:0] m,
                                                    input logic [RANK_W-1:0] ll);
        logic [MAX_WINDOW-1:0] s;
        for (int i = 0; i < MAX_WINDOW; i++)
            s[i] = m[i] && (RANK_W'(i) <= ll);
        return s;
    endfunction

    // Slot of each position: number of selected positions below it.
    function automatic rank_vec_t f_rank(input logic [MAX_WINDOW-1:0] s);
        rank_vec_t r;
        for (int i = 0; i < MAX_WINDOW; i++)
            r[i] = RANK_W'($countones(s & ((MAX_WINDOW)'(1) << i) - (MAX_WINDOW)'(1)));
        return r;
    endfunction

    always_comb
    begin
        window_length_next = window_length_reg;
        select_mask_next   = select_mask_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_LENGTH: window_length_next = cfg_wdata[LEN_W-1:0];
                REG_SELECT_MASK:   select_mask_next   = cfg_wdata[MASK_W-1:0];
                default: ;
            endcase
        end
        len_last_next = f_len_last(window_length_next);
        sel_next      = f_sel(select_mask_next, len_last_next);
        rank_next     = f_rank(sel_next);
        count_next    = COUNT_W'($countones(sel_next));

        len_last_rst  = f_len_last(LEN_RESET);
        sel_rst       = f_sel(MASK_RESET, len_last_rst);
        rank_rst      = f_rank(sel_rst);
        count_rst     = COUNT_W'($countones(sel_rst));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= LEN_RESET;
            select_mask_reg   <= MASK_RESET;
            len_last_reg      <= len_last_rst;
            sel_reg           <= sel_rst;
            rank_reg          <= rank_rst;
            count_reg         <= count_rst;
        end
        else
        begin
            window_length_reg <= window_length_next;
            select_mask_reg   <= select_mask_next;
            len_last_reg      <= len_last_next;
            sel_reg           <= sel_next;
            rank_reg          <= rank_next;
            count_reg         <= count_next;
        end
    end

    assign len_last = len_last_reg;
    assign sel      = sel_reg;
    assign rank     = rank_reg;
    assign count    = count_reg;

endmodule

FILE: rtl/core/mkw_window.sv
// Sliding base window kept oldest first, with the newest base at the length tap.
`timescale 1ns / 1ps

module mkw_window
    import mkw_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int RANK_W     = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  logic              step,
    input  logic [CHAR_W-1:0] base_char,
    input  logic [RANK_W-1:0] len_last,
    output logic              accepted,
    output base_t             evicted,
    output base_t             view [MAX_WINDOW]
);

    base_t win_reg   [MAX_WINDOW];
    base_t win_next  [MAX_WINDOW];
    base_t upper     [MAX_WINDOW];
    base_t code;

    assign code     = decode_base(base_char);
    assign accepted = (code != BASE_BAD);
    assign evicted  = accepted ? win_reg[0] : BASE_N;

    for (genvar g = 0; g < MAX_WINDOW; g++)
    begin : g_upper
        if (g < MAX_WINDOW - 1)
        begin : g_inner
            assign upper[g] = win_reg[g+1];
        end
        else
        begin : g_top
            assign upper[g] = BASE_N;
        end
    end

    // Shift toward the oldest end and drop the new base at the last live tap.
    always_comb
    begin
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            if (RANK_W'(i) == len_last)
                win_next[i] = code;
            else if (RANK_W'(i) < len_last)
                win_next[i] = upper[i];
            else
                win_next[i] = win_reg[i];
            view[i] = accepted ? win_next[i] : win_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WINDOW; i++)
                win_reg[i] <= BASE_N;
        end
        else if (clear)
        begin
            for (int i = 0; i < MAX_WINDOW; i++)
                win_reg[i] <= BASE_N;
        end
        else if (step && accepted)
        begin
            win_reg <= win_next;
        end
    end

endmodule

FILE: rtl/core/mkw_compact.sv
// Packs the selected window positions into consecutive result slots.
`timescale 1ns / 1ps

module mkw_compact
    import mkw_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int RANK_W     = 5
) (
    input  base_t                              view [MAX_WINDOW],
    input  logic [MAX_WINDOW-1:0]              sel,
    input  logic [MAX_WINDOW-1:0][RANK_W-1:0]  rank,
    output logic [CODES_W-1:0]                 codes,
    output logic [FLAGS_W-1:0]                 n_flags
);

    always_comb
    begin
        logic  hit;
        base_t b;
        codes   = '0;
        n_flags = '0;
        for (int j = 0; j < MAX_WINDOW; j++)
        begin
            hit = 1'b0;
            b   = '0;
            for (int i = 0; i < MAX_WINDOW; i++)
            begin
                if (sel[i] && (rank[i] == RANK_W'(j)))
                begin
                    hit = 1'b1;
                    b   = b | view[i];
                end
            end
            if (hit)
            begin
                if (b == BASE_N)
                    n_flags[j] = 1'b1;
                else
                    codes[2*j +: 2] = b[1:0];
            end
        end
    end

endmodule

FILE: rtl/core/masked_kmer_window.sv
// Masked k-mer window top level: input stage, window, compaction and result register.
//
// Usage:
//   base_in carries one ASCII character per word; result_out returns exactly one
//   word per input word, in order. A, C, G, T and N (upper case) shift into the
//   window and push the oldest base out; any other character is flagged as not
//   accepted and leaves the window as it was.
//   The config port writes window_length (index 0) or select_mask (index 1) with
//   cfg_we; write only while no word is in flight. Writing window_length empties
//   the window to all N.
//   The word sits in the input register, then window update and mask compaction
//   land in the result register. Throughput is one word per cycle while
//   result_out is not stalled, set by the single window update per cycle; the
//   position-to-slot map is precomputed from the registers.
//   Reset: window all N, length 32, mask all ones, both stages empty.
//   When result_out stalls, the result register holds; the input register takes
//   one more word, and then base_in.ready drops until the receiver takes a word.
`timescale 1ns / 1ps

module masked_kmer_window
    import mkw_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    mkw_stream_if.sink           base_in,
    mkw_stream_if.source         result_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

`include "masked_kmer_window_assert.svh"

    localparam int RANK_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic              s1_valid_reg;
    logic [CHAR_W-1:0] s1_char_reg;
    logic              res_valid_reg;
    out_word_t         res_reg;
    logic              advance;
    logic              len_write;

    logic [RANK_W-1:0]                 len_last;
    logic [MAX_WINDOW-1:0]             sel;
    logic [MAX_WINDOW-1:0][RANK_W-1:0] rank;
    logic [COUNT_W-1:0]                count;

    logic               win_accepted;
    base_t              win_evicted;
    base_t              win_view [MAX_WINDOW];
    logic [CODES_W-1:0] codes;
    logic [FLAGS_W-1:0] n_flags;

    assign advance   = s1_valid_reg && (!res_valid_reg || result_out.ready);
    assign len_write = cfg_we && (cfg_index == REG_WINDOW_LENGTH);

    assign base_in.ready      = !s1_valid_reg || advance;
    assign result_out.valid   = res_valid_reg;
    assign result_out.payload = res_reg;

    mkw_sel_map #(
        .MAX_WINDOW (MAX_WINDOW),
        .RANK_W     (RANK_W)
    ) u_sel_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .len_last  (len_last),
        .sel       (sel),
        .rank      (rank),
        .count     (count)
    );

    mkw_window #(
        .MAX_WINDOW (MAX_WINDOW),
        .RANK_W     (RANK_W)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (len_write),
        .step      (advance),
        .base_char (s1_char_reg),
        .len_last  (len_last),
        .accepted  (win_accepted),
        .evicted   (win_evicted),
        .view      (win_view)
    );

    mkw_compact #(
        .MAX_WINDOW (MAX_WINDOW),
        .RANK_W     (RANK_W)
    ) u_compact (
        .view    (win_view),
        .sel     (sel),
        .rank    (rank),
        .codes   (codes),
        .n_flags (n_flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (base_in.valid && base_in.ready)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                res_valid_reg <= 1'b1;
            else if (result_out.ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Payload registers: load on handshake, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (base_in.valid && base_in.ready)
            s1_char_reg <= base_in.payload.base_char;
        if (advance)
        begin
            res_reg.accepted         <= win_accepted;
            res_reg.evicted_base     <= win_evicted;
            res_reg.selected_codes   <= codes;
            res_reg.selected_n_flags <= n_flags;
            res_reg.selected_count   <= count;
        end
    end

    `MKW_ASSERT_IMP(a_reject_evicts_n,
        result_out.valid && !result_out.payload.accepted,
        result_out.payload.evicted_base == BASE_N,
        "rejected word must report N as evicted base")

    `MKW_ASSERT_IMP(a_flags_within_count,
        result_out.valid,
        $countones(result_out.payload.selected_n_flags) <= 32'(result_out.payload.selected_count),
        "more N flags than selected slots")

    `MKW_ASSERT_IMP(a_full_stall_blocks_input,
        s1_valid_reg && res_valid_reg && !result_out.ready,
        !base_in.ready,
        "input taken while both stages are full and output stalled")

    `MKW_ASSERT_NXT(a_advance_fills_result,
        advance,
        res_valid_reg,
        "result register empty after an advance")

endmodule
